>>> rtl/lzbd_pkg.sv
// Shared types and constants for the LZ bit-stream decompressor.
package lzbd_pkg;

    localparam int WINDOW_SIZE_DEF      = 8192;
    localparam int BIT_BUFFER_WIDTH_DEF = 64;
    localparam int SIZE_W               = 24;
    localparam int OFF_W                = 13;
    localparam int LEN_W                = 17;

    localparam logic [7:0] MAGIC0_V0 = 8'd68;
    localparam logic [7:0] MAGIC1_V0 = 8'd83;
    localparam logic [7:0] MAGIC0_V1 = 8'd74;
    localparam logic [7:0] MAGIC1_V1 = 8'd77;

    localparam logic [OFF_W-1:0] NOOP_OFFSET = 13'h113F;
    localparam logic [OFF_W-1:0] LONG_BIAS   = 13'h140;
    localparam logic [OFF_W-1:0] MID_BIAS    = 13'h040;
    localparam logic [7:0]       LIT_HIGH    = 8'h80;

    localparam logic [1:0] CFG_VARIANT = 2'd0;
    localparam logic [1:0] CFG_OSIZE   = 2'd1;
    localparam logic [1:0] CFG_ISIZE   = 2'd2;

    typedef enum logic [3:0] {
        ST_OK     = 4'd0,
        ST_BYTE   = 4'd1,
        ST_NEED   = 4'd2,
        ST_DONE   = 4'd3,
        ST_FULL   = 4'd4,
        ST_HEADER = 4'd5,
        ST_LENGTH = 4'd6,
        ST_OFFSET = 4'd7,
        ST_TRUNC  = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        PH_TOKEN  = 2'd0,
        PH_LENGTH = 2'd1,
        PH_COPY   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        TK_LIT   = 2'd0,
        TK_NOOP  = 2'd1,
        TK_BAD   = 2'd2,
        TK_MATCH = 2'd3
    } tok_kind_t;

    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_HDR     = 4'd1,
        OP_PUSH    = 4'd2,
        OP_TOKEN   = 4'd3,
        OP_LITERAL = 4'd4,
        OP_LENGTH  = 4'd5,
        OP_READ    = 4'd6,
        OP_COPY    = 4'd7,
        OP_CLEAR   = 4'd8
    } dp_op_t;

    typedef struct packed {
        logic      hdr_done;
        logic      in_small;
        logic      pushed_all;
        logic      buf_full;
        logic      hdr_bad;
        logic      out_done;
        phase_t    phase;
        logic      copy_zero;
        logic      tok_short;
        tok_kind_t tok_kind;
        logic      len_bad;
        logic      len_short;
        logic [7:0] lit_byte;
        logic [7:0] copy_byte;
        logic      emit_last;
    } dp_stat_t;

endpackage

>>> rtl/lzbd_dp.sv
// Datapath: configuration, bit buffer, token and length decode, history window.
module lzbd_dp #(
    parameter int WINDOW_SIZE      = lzbd_pkg::WINDOW_SIZE_DEF,
    parameter int BIT_BUFFER_WIDTH = lzbd_pkg::BIT_BUFFER_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [lzbd_pkg::SIZE_W-1:0]     cfg_data,
    input  logic [7:0]                      byte_in,
    input  lzbd_pkg::dp_op_t                op,
    output lzbd_pkg::dp_stat_t              stat
);

    localparam int WPW = $clog2(WINDOW_SIZE);
    localparam int CW  = $clog2(BIT_BUFFER_WIDTH + 1);
    localparam int SW  = lzbd_pkg::SIZE_W;
    localparam int OW  = lzbd_pkg::OFF_W;
    localparam int LW  = lzbd_pkg::LEN_W;

    logic                        variant_reg;
    logic [SW-1:0]               osize_reg;
    logic [SW-1:0]               isize_reg;
    logic [WPW-1:0]              wp_reg;
    logic [BIT_BUFFER_WIDTH-1:0] buf_reg;
    logic [CW-1:0]               cnt_reg;
    logic [2:0]                  hdr_reg;
    logic [SW-1:0]               pushed_reg;
    logic [SW-1:0]               emitted_reg;
    lzbd_pkg::phase_t            phase_reg;
    logic [OW-1:0]               off_reg;
    logic [LW-1:0]               remain_reg;
    logic [7:0]                  rd_reg;
    logic [7:0]                  mem [WINDOW_SIZE];

    logic [1:0]                  pfx_len;
    logic                        sel_high;
    logic                        sel_lit;
    logic                        sel_long;
    logic [15:0]                 tok_bits;
    logic [4:0]                  tok_need;
    logic [OW-1:0]               tok_off;
    logic [6:0]                  lit_val;
    lzbd_pkg::tok_kind_t         tok_kind;

    logic                        one_found;
    logic [3:0]                  zrun;
    logic [4:0]                  len_need;
    logic [31:0]                 len_bits;
    logic [31:0]                 len_mask;
    logic [14:0]                 len_val;
    logic [LW-1:0]               len_total;

    logic [CW-1:0]               eat;
    logic [WPW-1:0]              rd_addr;
    logic [7:0]                  magic0;
    logic [7:0]                  magic1;

    // token prefix
    always_comb
    begin
        pfx_len  = 2'd2;
        sel_lit  = 1'b0;
        sel_high = 1'b0;
        sel_long = 1'b0;
        if (!variant_reg)
        begin
            unique case (buf_reg[1:0])
                2'b10:   sel_lit = 1'b1;
                2'b01:
                begin
                    sel_lit  = 1'b1;
                    sel_high = 1'b1;
                end
                2'b11:   sel_long = 1'b1;
                default: sel_long = 1'b0;
            endcase
        end
        else if (!buf_reg[0])
        begin
            pfx_len = 2'd1;
            sel_lit = 1'b1;
        end
        else if (buf_reg[1])
        begin
            sel_lit  = 1'b1;
            sel_high = 1'b1;
        end
        else
        begin
            pfx_len  = 2'd3;
            sel_long = buf_reg[2];
        end
    end

    assign tok_bits = buf_reg[15:0] >> pfx_len;
    assign lit_val  = tok_bits[6:0];

    always_comb
    begin
        if (sel_lit)
        begin
            tok_need = 5'(pfx_len) + 5'd7;
            tok_off  = '0;
        end
        else if (sel_long)
        begin
            if (tok_bits[0])
            begin
                tok_need = 5'(pfx_len) + 5'd13;
                tok_off  = OW'(tok_bits[12:1]) + lzbd_pkg::LONG_BIAS;
            end
            else
            begin
                tok_need = 5'(pfx_len) + 5'd9;
                tok_off  = OW'(tok_bits[8:1]) + lzbd_pkg::MID_BIAS;
            end
        end
        else
        begin
            tok_need = 5'(pfx_len) + 5'd6;
            tok_off  = OW'(tok_bits[5:0]);
        end
    end

    always_comb
    begin
        if (sel_lit)
            tok_kind = lzbd_pkg::TK_LIT;
        else if (tok_off == lzbd_pkg::NOOP_OFFSET)
            tok_kind = lzbd_pkg::TK_NOOP;
        else if (tok_off == '0 || SW'(tok_off) > emitted_reg)
            tok_kind = lzbd_pkg::TK_BAD;
        else
            tok_kind = lzbd_pkg::TK_MATCH;
    end

    // unary length prefix
    always_comb
    begin
        zrun = 4'd0;
        for (int i = 15; i >= 0; i--)
        begin
            if (buf_reg[i])
                zrun = 4'(i);
        end
    end

    assign one_found = |buf_reg[15:0];
    assign len_need  = {zrun, 1'b1};
    assign len_bits  = buf_reg[31:0] >> (5'(zrun) + 5'd1);
    assign len_mask  = (32'd1 << zrun) - 32'd1;
    assign len_val   = 15'(len_bits & len_mask);

    always_comb
    begin
        if (zrun == 4'd0)
            len_total = LW'(2) + LW'(variant_reg);
        else
            len_total = (LW'(1) << zrun) + LW'(len_val) + LW'(1) + LW'(variant_reg);
    end

    assign magic0  = variant_reg ? lzbd_pkg::MAGIC0_V1 : lzbd_pkg::MAGIC0_V0;
    assign magic1  = variant_reg ? lzbd_pkg::MAGIC1_V1 : lzbd_pkg::MAGIC1_V0;
    assign rd_addr = wp_reg - WPW'(off_reg);
    assign eat     = (op == lzbd_pkg::OP_LENGTH) ? CW'(len_need) : CW'(tok_need);

    always_comb
    begin
        stat.hdr_done   = (hdr_reg == 3'd4);
        stat.in_small   = (isize_reg <= SW'(4));
        stat.pushed_all = (pushed_reg >= isize_reg);
        stat.buf_full   = (cnt_reg > CW'(BIT_BUFFER_WIDTH - 8));
        stat.hdr_bad    = (hdr_reg == 3'd0 && byte_in != magic0)
                       || (hdr_reg == 3'd1 && byte_in != magic1);
        stat.out_done   = (emitted_reg >= osize_reg);
        stat.phase      = phase_reg;
        stat.copy_zero  = (remain_reg == '0);
        stat.tok_short  = (CW'(tok_need) > cnt_reg);
        stat.tok_kind   = tok_kind;
        stat.len_bad    = !one_found && (cnt_reg >= CW'(16));
        stat.len_short  = !one_found || (CW'(len_need) > cnt_reg);
        stat.lit_byte   = sel_high ? ({1'b0, lit_val} | lzbd_pkg::LIT_HIGH) : {1'b0, lit_val};
        stat.copy_byte  = rd_reg;
        stat.emit_last  = ((emitted_reg + SW'(1)) == osize_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= 1'b0;
            osize_reg   <= '0;
            isize_reg   <= '0;
            wp_reg      <= '0;
            buf_reg     <= '0;
            cnt_reg     <= '0;
            hdr_reg     <= '0;
            pushed_reg  <= '0;
            emitted_reg <= '0;
            phase_reg   <= lzbd_pkg::PH_TOKEN;
            off_reg     <= '0;
            remain_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lzbd_pkg::CFG_VARIANT: variant_reg <= cfg_data[0];
                    lzbd_pkg::CFG_OSIZE:   osize_reg   <= cfg_data;
                    lzbd_pkg::CFG_ISIZE:   isize_reg   <= cfg_data;
                    default:               variant_reg <= variant_reg;
                endcase
            end
            unique case (op)
                lzbd_pkg::OP_HDR:
                begin
                    hdr_reg    <= hdr_reg + 3'd1;
                    pushed_reg <= pushed_reg + SW'(1);
                end
                lzbd_pkg::OP_PUSH:
                begin
                    buf_reg    <= buf_reg | (BIT_BUFFER_WIDTH'(byte_in) << cnt_reg);
                    cnt_reg    <= cnt_reg + CW'(8);
                    pushed_reg <= pushed_reg + SW'(1);
                end
                lzbd_pkg::OP_TOKEN:
                begin
                    buf_reg <= buf_reg >> eat;
                    cnt_reg <= cnt_reg - eat;
                    if (tok_kind == lzbd_pkg::TK_MATCH)
                    begin
                        off_reg   <= tok_off;
                        phase_reg <= lzbd_pkg::PH_LENGTH;
                    end
                end
                lzbd_pkg::OP_LITERAL:
                begin
                    buf_reg     <= buf_reg >> eat;
                    cnt_reg     <= cnt_reg - eat;
                    wp_reg      <= wp_reg + WPW'(1);
                    emitted_reg <= emitted_reg + SW'(1);
                end
                lzbd_pkg::OP_LENGTH:
                begin
                    buf_reg    <= buf_reg >> eat;
                    cnt_reg    <= cnt_reg - eat;
                    remain_reg <= len_total;
                    phase_reg  <= lzbd_pkg::PH_COPY;
                end
                lzbd_pkg::OP_READ:
                begin
                    remain_reg <= remain_reg - LW'(1);
                    if (remain_reg == LW'(1))
                        phase_reg <= lzbd_pkg::PH_TOKEN;
                end
                lzbd_pkg::OP_COPY:
                begin
                    wp_reg      <= wp_reg + WPW'(1);
                    emitted_reg <= emitted_reg + SW'(1);
                end
                lzbd_pkg::OP_CLEAR: phase_reg <= lzbd_pkg::PH_TOKEN;
                default:            phase_reg <= phase_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == lzbd_pkg::OP_LITERAL)
            mem[wp_reg] <= stat.lit_byte;
        if (op == lzbd_pkg::OP_COPY)
            mem[wp_reg] <= rd_reg;
        if (op == lzbd_pkg::OP_READ)
            rd_reg <= mem[rd_addr];
    end

endmodule

>>> rtl/lzbd_ctrl.sv
// Controller: word handshake, decode sequencing, result register and error latch.
module lzbd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 func,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic [3:0]           m_tuser,
    output logic                 m_tlast,
    input  lzbd_pkg::dp_stat_t   stat,
    output lzbd_pkg::dp_op_t     op
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_DECODE = 2'd1,
        S_READ   = 2'd2
    } state_t;

    state_t            state_reg, state_next;
    lzbd_pkg::status_t err_reg, err_next;
    logic              ovalid_reg, ovalid_next;
    lzbd_pkg::status_t ostatus_reg, ostatus_next;
    logic [7:0]        obyte_reg, obyte_next;
    logic              olast_reg, olast_next;

    logic              accept;
    logic              fin;
    logic              fin_err;
    lzbd_pkg::status_t fin_st;
    logic [7:0]        fin_byte;
    logic              fin_last;

    assign s_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        op         = lzbd_pkg::OP_NONE;
        fin        = 1'b0;
        fin_err    = 1'b0;
        fin_st     = lzbd_pkg::ST_OK;
        fin_byte   = 8'd0;
        fin_last   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fin = 1'b1;
                    if (err_reg != lzbd_pkg::ST_OK)
                        fin_st = err_reg;
                    else if (!func)
                    begin
                        if (!stat.hdr_done)
                        begin
                            if (stat.in_small || (!stat.pushed_all && stat.hdr_bad))
                            begin
                                fin_st  = lzbd_pkg::ST_HEADER;
                                fin_err = 1'b1;
                            end
                            else if (stat.pushed_all)
                                fin_st = lzbd_pkg::ST_FULL;
                            else
                                op = lzbd_pkg::OP_HDR;
                        end
                        else if (stat.pushed_all || stat.buf_full)
                            fin_st = lzbd_pkg::ST_FULL;
                        else
                            op = lzbd_pkg::OP_PUSH;
                    end
                    else if (!stat.hdr_done)
                    begin
                        fin_st  = stat.in_small ? lzbd_pkg::ST_HEADER : lzbd_pkg::ST_NEED;
                        fin_err = stat.in_small;
                    end
                    else if (stat.out_done)
                        fin_st = lzbd_pkg::ST_DONE;
                    else
                    begin
                        fin        = 1'b0;
                        state_next = S_DECODE;
                    end
                end
            end
            S_DECODE:
            begin
                unique case (stat.phase)
                    lzbd_pkg::PH_COPY:
                    begin
                        if (stat.copy_zero)
                            op = lzbd_pkg::OP_CLEAR;
                        else
                        begin
                            op         = lzbd_pkg::OP_READ;
                            state_next = S_READ;
                        end
                    end
                    lzbd_pkg::PH_LENGTH:
                    begin
                        if (stat.len_bad)
                        begin
                            fin     = 1'b1;
                            fin_st  = lzbd_pkg::ST_LENGTH;
                            fin_err = 1'b1;
                        end
                        else if (stat.len_short)
                        begin
                            fin     = 1'b1;
                            fin_st  = stat.pushed_all ? lzbd_pkg::ST_TRUNC : lzbd_pkg::ST_NEED;
                            fin_err = stat.pushed_all;
                        end
                        else
                            op = lzbd_pkg::OP_LENGTH;
                    end
                    default:
                    begin
                        if (stat.tok_short)
                        begin
                            fin     = 1'b1;
                            fin_st  = stat.pushed_all ? lzbd_pkg::ST_TRUNC : lzbd_pkg::ST_NEED;
                            fin_err = stat.pushed_all;
                        end
                        else
                        begin
                            unique case (stat.tok_kind)
                                lzbd_pkg::TK_LIT:
                                begin
                                    op       = lzbd_pkg::OP_LITERAL;
                                    fin      = 1'b1;
                                    fin_st   = lzbd_pkg::ST_BYTE;
                                    fin_byte = stat.lit_byte;
                                    fin_last = stat.emit_last;
                                end
                                lzbd_pkg::TK_BAD:
                                begin
                                    fin     = 1'b1;
                                    fin_st  = lzbd_pkg::ST_OFFSET;
                                    fin_err = 1'b1;
                                end
                                default: op = lzbd_pkg::OP_TOKEN;
                            endcase
                        end
                    end
                endcase
            end
            S_READ:
            begin
                op       = lzbd_pkg::OP_COPY;
                fin      = 1'b1;
                fin_st   = lzbd_pkg::ST_BYTE;
                fin_byte = stat.copy_byte;
                fin_last = stat.emit_last;
            end
            default: state_next = S_IDLE;
        endcase

        err_next     = err_reg;
        ovalid_next  = ovalid_reg && !m_tready;
        ostatus_next = ostatus_reg;
        obyte_next   = obyte_reg;
        olast_next   = olast_reg;
        if (fin)
        begin
            state_next   = S_IDLE;
            ovalid_next  = 1'b1;
            ostatus_next = fin_st;
            obyte_next   = fin_byte;
            olast_next   = fin_last;
            if (fin_err)
                err_next = fin_st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            err_reg     <= lzbd_pkg::ST_OK;
            ovalid_reg  <= 1'b0;
            ostatus_reg <= lzbd_pkg::ST_OK;
            obyte_reg   <= 8'd0;
            olast_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            err_reg     <= err_next;
            ovalid_reg  <= ovalid_next;
            ostatus_reg <= ostatus_next;
            obyte_reg   <= obyte_next;
            olast_reg   <= olast_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = obyte_reg;
    assign m_tuser  = ostatus_reg;
    assign m_tlast  = olast_reg;

`ifndef SYNTHESIS
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != lzbd_pkg::ST_OK |=> $stable(err_reg))
        else $error("error latch changed");

    a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && olast_reg |-> ostatus_reg == lzbd_pkg::ST_BYTE)
        else $error("last without byte");

    a_read_one: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> state_reg == S_IDLE && ovalid_reg)
        else $error("copy read did not finish");

    a_err_match: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && ostatus_reg >= lzbd_pkg::ST_HEADER |-> err_reg == ostatus_reg)
        else $error("error result not latched");
`endif

endmodule

>>> rtl/lz_bitstream_decompressor.sv
// Top level of the LZ bit-stream decompressor.
//  channel | direction | handshake         | payload
//  s_      | in        | s_tvalid/s_tready | s_tuser func, s_tdata byte_in
//  m_      | out       | m_tvalid/m_tready | m_tuser status, m_tdata byte_out, m_tlast last
//  cfg_    | in        | cfg_we            | cfg_index register, cfg_data value
// A push word finishes in its accept cycle; a pull is accepted in S_IDLE, then decodes in S_DECODE
// one step at a time (token prefix with offset, no-op marker, length code, literal);
// a copied byte is read from the single-port history window with registered read in
// S_DECODE and sent out from S_READ. One word is in flight; the next is taken once
// the result register is empty. Reset clears all control state; the window is not cleared.
module lz_bitstream_decompressor #(
    parameter int WINDOW_SIZE      = lzbd_pkg::WINDOW_SIZE_DEF,
    parameter int BIT_BUFFER_WIDTH = lzbd_pkg::BIT_BUFFER_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // byte_in
    input  logic [0:0]                  s_tuser,   // func
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // byte_out
    output logic [3:0]                  m_tuser,   // status
    output logic                        m_tlast,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [lzbd_pkg::SIZE_W-1:0] cfg_data
);

    lzbd_pkg::dp_op_t   op;
    lzbd_pkg::dp_stat_t stat;

    lzbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .stat     (stat),
        .op       (op)
    );

    lzbd_dp #(
        .WINDOW_SIZE      (WINDOW_SIZE),
        .BIT_BUFFER_WIDTH (BIT_BUFFER_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .byte_in   (s_tdata),
        .op        (op),
        .stat      (stat)
    );

endmodule
